// ----- hw/rtl/itr_pkg.sv -----
// Shared constants and the digit lookup for the radix text converter.
package itr_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 5;
  localparam int CHAR_W         = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  // Map one digit value to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 7'h30;
      4'd1:    c = 7'h31;
      4'd2:    c = 7'h32;
      4'd3:    c = 7'h33;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h37;
      4'd8:    c = 7'h38;
      4'd9:    c = 7'h39;
      4'd10:   c = 7'h61;
      4'd11:   c = 7'h62;
      4'd12:   c = 7'h63;
      4'd13:   c = 7'h64;
      4'd14:   c = 7'h65;
      4'd15:   c = 7'h66;
      default: c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/integer_to_text_radix_top.sv -----
// Top level: converts an integer to ASCII text in radix 2 to 16, one character per beat.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+--------------------------
//  input   | in_value, in_radix, in_is_signed        | in        | start high, busy low
//  result  | out_character, out_last                 | out       | out_valid, one cycle each
//
// Each digit comes from the bit-serial divider; a minus sign, if any, is written after the
// digits, and the characters are then replayed from the store, so the block takes no new item
// while busy is high; 1 to VALUE_BITS+1 beats per item.
// Reset (rst_n low, synchronous) returns the sequencer to idle; the store needs no clearing.
// The receiver cannot stall: characters leave at one per cycle once replay begins.
module integer_to_text_radix_top #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  logic [itr_pkg::RADIX_W-1:0]   in_radix,
  input  logic                          in_is_signed,
  output logic                          out_valid,
  output logic [itr_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last
);

  localparam int AW = $clog2(VALUE_BITS + 1);
  localparam int CW = $clog2(VALUE_BITS + 2);
  localparam int RW = itr_pkg::RADIX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic [RW-1:0]           radix_r, radix_nxt;
  logic                    valid_r, valid_nxt;
  logic                    last_r, last_nxt;

  logic [RW-1:0]           radix_sat;
  logic                    in_neg;
  logic [VALUE_BITS-1:0]   in_mag;

  logic                    div_start;
  logic [VALUE_BITS-1:0]   div_dividend;
  logic [RW-1:0]           div_radix;
  logic                    div_done;
  logic [VALUE_BITS-1:0]   div_quot;
  logic [RW-1:0]           div_rem;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [itr_pkg::CHAR_W-1:0] wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [CW-1:0]           cnt_dec;

  // Saturate the radix and take the magnitude of the value.
  always_comb begin
    if (in_radix < itr_pkg::RADIX_MIN) begin
      radix_sat = itr_pkg::RADIX_MIN;
    end else if (in_radix > itr_pkg::RADIX_MAX) begin
      radix_sat = itr_pkg::RADIX_MAX;
    end else begin
      radix_sat = in_radix;
    end
    in_neg = in_is_signed & in_value[VALUE_BITS-1];
    in_mag = in_neg ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;
  end

  assign cnt_dec = cnt_r - 1'b1;

  // Sequence divide steps, the sign, then replay the store backwards.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    radix_nxt    = radix_r;
    valid_nxt    = 1'b0;
    last_nxt     = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_radix    = radix_r;
    wr_en        = 1'b0;
    wr_addr      = cnt_r[AW-1:0];
    wr_data      = itr_pkg::digit_char(div_rem[3:0]);
    rd_en        = 1'b0;
    rd_addr      = cnt_dec[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          div_start    = 1'b1;
          div_dividend = in_mag;
          div_radix    = radix_sat;
          radix_nxt    = radix_sat;
          neg_nxt      = in_neg;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else if (neg_r) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        wr_en     = 1'b1;
        wr_data   = itr_pkg::CHAR_MINUS;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        rd_en     = 1'b1;
        cnt_nxt   = cnt_dec;
        valid_nxt = 1'b1;
        if (cnt_r == CW'(1)) begin
          last_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  // Hold per-item operands.
  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    radix_r <= radix_nxt;
  end

  itr_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (div_radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  itr_store #(
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_character)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_last  = last_r;

endmodule

// ----- hw/rtl/itr_div.sv -----
// Bit-serial restoring divider: divides a value by a small radix, one bit per cycle.
module itr_div #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [itr_pkg::RADIX_W-1:0]   radix,
  output logic                          done,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [itr_pkg::RADIX_W-1:0]   remainder
);

  localparam int SW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int RW = itr_pkg::RADIX_W;

  logic [VALUE_BITS-1:0] q_r;
  logic [RW-1:0]         rem_r;
  logic [RW-1:0]         radix_r;
  logic                  busy_r;
  logic                  done_r;
  logic [SW-1:0]         step_r;

  logic [RW:0]           trial;
  logic [RW:0]           diff;
  logic                  fits;
  logic [RW-1:0]         rem_nxt;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial   = {rem_r, q_r[VALUE_BITS-1]};
    diff    = trial - {1'b0, radix_r};
    fits    = (trial >= {1'b0, radix_r});
    rem_nxt = fits ? diff[RW-1:0] : trial[RW-1:0];
  end

  // Sequence the steps and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(VALUE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r     <= dividend;
      rem_r   <= '0;
      radix_r <= radix;
    end else if (busy_r) begin
      q_r   <= {q_r[VALUE_BITS-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/itr_store.sv -----
// Character store: one write port and one registered read port.
module itr_store #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [$clog2(VALUE_BITS+1)-1:0]           wr_addr,
  input  logic [itr_pkg::CHAR_W-1:0]                wr_data,
  input  logic                                      rd_en,
  input  logic [$clog2(VALUE_BITS+1)-1:0]           rd_addr,
  output logic [itr_pkg::CHAR_W-1:0]                rd_data
);

  localparam int DEPTH = VALUE_BITS + 1;

  logic [itr_pkg::CHAR_W-1:0] mem_r [DEPTH];
  logic [itr_pkg::CHAR_W-1:0] rd_data_r;

  // Write one character.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Register the read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the radix text converter: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;

  localparam int VB = 32;
  localparam int RW = itr_pkg::RADIX_W;
  localparam int CW = itr_pkg::CHAR_W;
  localparam logic [CW-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CW-1:0] ASCII_LOWER_A = 7'h61;
  localparam int RANDOM_ITEMS = 136;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [VB-1:0] value;
    logic [RW-1:0] radix;
    logic          is_signed;
  } conv_req_t;

  typedef struct packed {
    logic [CW-1:0] character;
    logic          last;
  } text_beat_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [VB-1:0] in_value = '0;
  logic [RW-1:0] in_radix = '0;
  logic          in_is_signed = 1'b0;
  logic          out_valid;
  logic [CW-1:0] out_character;
  logic          out_last;

  // Characters still owed by the block, oldest first
  text_beat_t pending_chars[$];
  int         error_count = 0;

  // Directed table: requests, with typed text where it is obvious ("" = use the predictor)
  conv_req_t  directed_reqs[$];
  string      directed_text[$];

  // Predictor's own copy of the converter state
  logic [VB-1:0] quot_model;
  logic [CW-1:0] digit_model[0:VB];
  logic [5:0]    count_model;

  integer_to_text_radix_top #(.VALUE_BITS(VB)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_radix     (in_radix),
    .in_is_signed (in_is_signed),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Divide down the magnitude, store digits low first, then queue them high first
  function automatic void predict_text(input conv_req_t req);
    logic [RW-1:0] base;
    logic          neg;
    logic [VB-1:0] digit;
    text_beat_t    beat;
    base = req.radix;
    if (base < itr_pkg::RADIX_MIN) begin
      base = itr_pkg::RADIX_MIN;
    end else if (base > itr_pkg::RADIX_MAX) begin
      base = itr_pkg::RADIX_MAX;
    end
    neg = req.is_signed && req.value[VB-1];
    quot_model = neg ? (~req.value + 1'b1) : req.value;
    count_model = '0;
    do begin
      digit = quot_model % base;
      digit_model[count_model] = (digit < 10) ? ASCII_ZERO + CW'(digit)
                                              : ASCII_LOWER_A + CW'(digit - 10);
      count_model = count_model + 1'b1;
      quot_model = quot_model / base;
    end while (quot_model != 0);
    if (neg) begin
      digit_model[count_model] = itr_pkg::CHAR_MINUS;
      count_model = count_model + 1'b1;
    end
    while (count_model > 0) begin
      count_model = count_model - 1'b1;
      beat.character = digit_model[count_model];
      beat.last = (count_model == 0);
      pending_chars.push_back(beat);
    end
  endfunction

  task automatic add_row(input logic [VB-1:0] v, input logic [RW-1:0] r,
                         input logic s, input string txt);
    conv_req_t req;
    req.value = v;
    req.radix = r;
    req.is_signed = s;
    directed_reqs.push_back(req);
    directed_text.push_back(txt);
  endtask

  // Drive one request after an optional gap, hold it until accepted, queue its text
  task automatic drive_item(input conv_req_t req, input int gap, input string txt);
    text_beat_t beat;
    byte        ch;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_value     <= req.value;
    in_radix     <= req.radix;
    in_is_signed <= req.is_signed;
    do @(posedge clk); while (busy);
    if (txt.len() == 0) begin
      predict_text(req);
    end else begin
      for (int i = 0; i < txt.len(); i++) begin
        ch = txt[i];
        beat.character = ch[CW-1:0];
        beat.last = (i == txt.len() - 1);
        pending_chars.push_back(beat);
      end
    end
  endtask

  // Drop start and wait until every owed character has come out
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    text_beat_t exp_beat;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: character %h last %b", out_character, out_last);
        error_count++;
      end else begin
        exp_beat = pending_chars.pop_front();
        if (out_character !== exp_beat.character) begin
          $error("character: expected %h, got %h", exp_beat.character, out_character);
          error_count++;
        end
        if (out_last !== exp_beat.last) begin
          $error("last: expected %b, got %b", exp_beat.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    conv_req_t req;
    int        burst_left;
    int        gap;

    // Zero, extremes, radix saturation and sign handling
    add_row(32'h0000_0000, 5'd10, 1'b0, "0");
    add_row(32'h0000_0000, 5'd2,  1'b1, "0");
    add_row(32'hFFFF_FFFF, 5'd16, 1'b0, "ffffffff");
    add_row(32'hFFFF_FFFF, 5'd10, 1'b0, "4294967295");
    add_row(32'hFFFF_FFFF, 5'd8,  1'b0, "37777777777");
    add_row(32'hFFFF_FFFF, 5'd2,  1'b0, "");
    add_row(32'hFFFF_FFFF, 5'd10, 1'b1, "-1");
    add_row(32'hFFFF_FFFF, 5'd16, 1'b1, "-1");
    add_row(32'h8000_0000, 5'd10, 1'b1, "-2147483648");
    add_row(32'h8000_0000, 5'd2,  1'b1, "");
    add_row(32'h8000_0000, 5'd16, 1'b0, "80000000");
    add_row(32'h8000_0000, 5'd3,  1'b0, "");
    add_row(32'h7FFF_FFFF, 5'd10, 1'b1, "2147483647");
    add_row(32'h0000_00FF, 5'd0,  1'b0, "11111111");
    add_row(32'h0000_00FF, 5'd1,  1'b0, "11111111");
    add_row(32'h0000_00FF, 5'd17, 1'b0, "ff");
    add_row(32'h0000_00FF, 5'd31, 1'b0, "ff");
    add_row(32'hFFFF_FF00, 5'd16, 1'b1, "-100");
    add_row(32'h0000_0023, 5'd16, 1'b1, "23");
    add_row(32'h0000_000F, 5'd16, 1'b0, "f");
    add_row(32'h0000_000A, 5'd11, 1'b0, "a");
    add_row(32'h0000_0001, 5'd2,  1'b1, "1");
    add_row(32'h0000_3039, 5'd7,  1'b1, "");
    add_row(32'hDEAD_BEEF, 5'd13, 1'b1, "");

    // Hold reset low at the start, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back
    foreach (directed_reqs[i]) begin
      drive_item(directed_reqs[i], 0, directed_text[i]);
    end
    hold_until_drained();

    // Random beats in bursts with random gaps
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 5))
        0, 1:    req.value = $urandom;
        2:       req.value = $urandom_range(0, 300);
        3:       req.value = 32'h8000_0000 + $urandom_range(0, 15);
        4:       req.value = ~$urandom_range(0, 300);
        default: req.value = 32'h8000_0000 | $urandom;
      endcase
      req.radix = ($urandom_range(0, 9) == 0) ? RW'($urandom_range(0, 31))
                                              : RW'($urandom_range(2, 16));
      req.is_signed = ($urandom_range(0, 1) == 1);
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 7);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 400) : $urandom_range(1, 6);
      end
      if (n == RANDOM_ITEMS / 2) begin
        hold_until_drained();
      end
      drive_item(req, gap, "");
    end

    // Drain and let the block settle
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d expected beats never arrived", pending_chars.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #12ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/itr_pkg.sv
hw/rtl/itr_div.sv
hw/rtl/itr_store.sv
hw/rtl/integer_to_text_radix_top.sv
bench/tb_top.sv
